FILE: rtl/wbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // fixed field widths
  localparam int unsigned AddrW   = 64;
  localparam int unsigned LenW    = 5;
  localparam int unsigned PatMax  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPatLow    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPatHigh   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWildMask  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPatLength = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRangeLo   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRangeHi   = 3'd5;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [8*PatMax-1:0] pattern;     // byte i in bits 8i+7:8i
    logic [PatMax-1:0]   wild;
    logic [LenW-1:0]     len;         // effective length, already capped
    logic [AddrW-1:0]    range_start;
    logic [AddrW-1:0]    range_end;
  } cfg_t;

  // input stage contents handed to the compare stage
  typedef struct packed {
    logic             valid;
    logic             pre_ok;         // fill and address checks passed
    logic [AddrW-1:0] start;          // address of first window byte
  } stage_t;

endpackage

FILE: rtl/wbps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_front
// Input stage: sliding byte window, region fill count and the address range
// checks, registered for the compare stage.
// ----------------------------------------------------------------------------
module wbps_front #(
  parameter int unsigned WIN_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wbps_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 byte_value_i,
  input  logic [wbps_pkg::AddrW-1:0] byte_address_i,
  input  logic                       region_first_i,
  input  logic                       take_i,
  output wbps_pkg::stage_t           stage_o,
  output logic [7:0]                 win_o [WIN_DEPTH]
);

  localparam int unsigned FillW = $clog2(WIN_DEPTH + 1);
  localparam logic [FillW-1:0] FillMax = FillW'(WIN_DEPTH);

  logic [7:0]                 win_q [WIN_DEPTH];
  logic [FillW-1:0]           fill_q, fill_d, fill_base;
  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_ok_q, s1_ok_d;
  logic [wbps_pkg::AddrW-1:0] s1_start_q, s1_start_d;
  logic [wbps_pkg::AddrW-1:0] len_m1;
  logic                       accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !s1_valid_q || take_i;

  // fill count after this byte, restarting on a new region
  always_comb begin
    fill_base = region_first_i ? '0 : fill_q;
    fill_d    = (fill_base < FillMax) ? fill_base + 1'b1 : fill_base;
  end

  // first-byte address and the checks that do not need the window
  always_comb begin
    len_m1     = wbps_pkg::AddrW'(cfg_i.len) - 1'b1;
    s1_start_d = byte_address_i - len_m1;
    s1_ok_d    = (cfg_i.len != '0)
              && (wbps_pkg::LenW'(fill_d) >= cfg_i.len)
              && (byte_address_i >= len_m1)
              && (s1_start_d >= cfg_i.range_start)
              && (byte_address_i < cfg_i.range_end);
  end

  // stage valid
  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (take_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  // window shift and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        fill_q   <= fill_d;
        win_q[0] <= byte_value_i;
        for (int k = 1; k < WIN_DEPTH; k++) begin
          win_q[k] <= region_first_i ? 8'h00 : win_q[k-1];
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_start_q <= s1_start_d;
      s1_ok_q    <= s1_ok_d;
    end
  end

  assign stage_o.valid  = s1_valid_q;
  assign stage_o.pre_ok = s1_ok_q;
  assign stage_o.start  = s1_start_q;
  assign win_o          = win_q;

endmodule

FILE: rtl/wbps_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_match
// Masked compare of the window against the pattern and the result register.
// ----------------------------------------------------------------------------
module wbps_match #(
  parameter int unsigned WIN_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wbps_pkg::cfg_t             cfg_i,
  input  wbps_pkg::stage_t           stage_i,
  input  logic [7:0]                 win_i [WIN_DEPTH],
  output logic                       take_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [wbps_pkg::AddrW-1:0] match_address_o
);

  logic                       out_valid_q, out_valid_d;
  logic [wbps_pkg::AddrW-1:0] match_address_q;
  logic                       bytes_ok;
  logic                       hit;

  assign take_o = !out_valid_q || out_ready_i;

  // pattern byte i lines up with the byte seen len-1-i steps ago
  always_comb begin
    logic [7:0]                sel;
    logic [wbps_pkg::LenW-1:0] pos;
    bytes_ok = 1'b1;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      pos = cfg_i.len - wbps_pkg::LenW'(i) - 1'b1;
      sel = 8'h00;
      for (int k = 0; k < WIN_DEPTH; k++) begin
        sel = sel | (win_i[k] & {8{pos == wbps_pkg::LenW'(k)}});
      end
      if ((wbps_pkg::LenW'(i) < cfg_i.len) && !cfg_i.wild[i]
          && (sel != cfg_i.pattern[8*i +: 8])) begin
        bytes_ok = 1'b0;
      end
    end
  end

  assign hit = stage_i.valid && stage_i.pre_ok && bytes_ok;

  // result valid
  always_comb begin
    out_valid_d = take_o ? hit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take_o && hit) begin
      match_address_q <= stage_i.start;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign match_address_o = match_address_q;

endmodule

FILE: rtl/wildcard_byte_pattern_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_unit
// Streaming wildcard byte signature search over memory regions.
// ----------------------------------------------------------------------------
// Takes one memory byte per cycle with its address and a region-start flag,
// and reports the address of the first byte of every window of the last
// pattern_length bytes that matches the pattern (wild positions match any
// byte) and lies fully inside [range_start, range_end). Input stalls while an
// untaken result holds the result register. The input stage (window shift
// and address checks) registers each byte, then the compare stage feeds the
// result register. Pattern length is capped at the smaller of 16 and
// MAX_PATTERN. Configuration must be written only while idle (not enforced);
// cfg_ready_o is always high and out-of-list indexes are ignored.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_unit #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wbps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [wbps_pkg::CfgW-1:0]    cfg_data_i,
  // byte stream
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   byte_value_i,
  input  logic [wbps_pkg::AddrW-1:0]   byte_address_i,
  input  logic                         region_first_i,
  // match results
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [wbps_pkg::AddrW-1:0]   match_address_o
);

  localparam int unsigned WinDepth =
    (MAX_PATTERN < wbps_pkg::PatMax) ? MAX_PATTERN : wbps_pkg::PatMax;
  localparam logic [wbps_pkg::LenW-1:0] LenCap = wbps_pkg::LenW'(WinDepth);

  logic [63:0]                 pat_lo_q, pat_hi_q;
  logic [15:0]                 wild_q;
  logic [wbps_pkg::LenW-1:0]   plen_q;
  logic [wbps_pkg::AddrW-1:0]  rstart_q, rend_q;
  logic                        cfg_we;
  wbps_pkg::cfg_t              cfg;
  wbps_pkg::stage_t            stage;
  logic [7:0]                  win [WinDepth];
  logic                        take;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      wild_q   <= '0;
      plen_q   <= wbps_pkg::LenW'(1);
      rstart_q <= '0;
      rend_q   <= '1;
    end else if (cfg_we) begin
      case (cfg_index_i)
        wbps_pkg::CfgPatLow:    pat_lo_q <= cfg_data_i;
        wbps_pkg::CfgPatHigh:   pat_hi_q <= cfg_data_i;
        wbps_pkg::CfgWildMask:  wild_q   <= cfg_data_i[15:0];
        wbps_pkg::CfgPatLength: plen_q   <= cfg_data_i[wbps_pkg::LenW-1:0];
        wbps_pkg::CfgRangeLo:   rstart_q <= cfg_data_i;
        wbps_pkg::CfgRangeHi:   rend_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // datapath view of the configuration, length capped to the window
  always_comb begin
    cfg.pattern     = {pat_hi_q, pat_lo_q};
    cfg.wild        = wild_q;
    cfg.len         = (plen_q > LenCap) ? LenCap : plen_q;
    cfg.range_start = rstart_q;
    cfg.range_end   = rend_q;
  end

  // input stage
  wbps_front #(
    .WIN_DEPTH (WinDepth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_value_i   (byte_value_i),
    .byte_address_i (byte_address_i),
    .region_first_i (region_first_i),
    .take_i         (take),
    .stage_o        (stage),
    .win_o          (win)
  );

  // compare stage and result register
  wbps_match #(
    .WIN_DEPTH (WinDepth)
  ) u_match (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .stage_i         (stage),
    .win_i           (win),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .match_address_o (match_address_o)
  );

endmodule
